// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// concurrent checks on the rising clock edge, disabled while in reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define RTVS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed");
`define RTVS_ASSERT_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("forbidden condition seen");
`else
`define RTVS_ASSERT(lbl, prop)
`define RTVS_ASSERT_NEVER(lbl, expr)
`endif
`endif

// ===== rtl/rtvs_pkg.sv =====
// ----------------------------------------------------------------------------
// rtvs_pkg
// widths and shared types of the running two-variable statistics core
// ----------------------------------------------------------------------------
package rtvs_pkg;

  localparam int unsigned ACC_W     = 32;
  localparam int unsigned XY_W      = 47;
  localparam int unsigned SQ_W      = 46;
  localparam int unsigned MUL_W     = 32;
  localparam int unsigned PROD_W    = 2 * MUL_W;
  localparam int unsigned DIV_W     = 64;
  localparam int unsigned CNT_OUT_W = 16;
  localparam int unsigned MEAN_W    = 16;
  localparam int unsigned VAR_W     = 32;
  localparam int unsigned DEV_W     = 16;
  localparam int unsigned SQRT_STEPS = VAR_W / 2;

  typedef struct packed {
    logic busy;
    logic done;
  } rtvs_stat_t;

endpackage

// ===== rtl/rtvs_in_if.sv =====
// ----------------------------------------------------------------------------
// rtvs_in_if
// input channel: action and one x,y sample pair
// ----------------------------------------------------------------------------
interface rtvs_in_if #(parameter int unsigned SAMPLE_WIDTH = 16);
  logic                           valid;
  logic                           ready;
  logic                           action;
  logic signed [SAMPLE_WIDTH-1:0] x_sample;
  logic signed [SAMPLE_WIDTH-1:0] y_sample;

  modport source (output valid, action, x_sample, y_sample, input ready);
  modport sink   (input valid, action, x_sample, y_sample, output ready);
endinterface

// ===== rtl/rtvs_out_if.sv =====
// ----------------------------------------------------------------------------
// rtvs_out_if
// output channel: sums, means, variances and deviations
// ----------------------------------------------------------------------------
interface rtvs_out_if;
  logic               valid;
  logic               ready;
  logic [15:0]        count;
  logic signed [31:0] sum_x;
  logic signed [31:0] sum_y;
  logic signed [46:0] sum_xy;
  logic [45:0]        sum_xx;
  logic [45:0]        sum_yy;
  logic signed [15:0] mean_x;
  logic signed [15:0] mean_y;
  logic [31:0]        variance_x;
  logic [31:0]        variance_y;
  logic [15:0]        deviation_x;
  logic [15:0]        deviation_y;

  modport source (output valid, count, sum_x, sum_y, sum_xy, sum_xx, sum_yy, mean_x,
                  mean_y, variance_x, variance_y, deviation_x, deviation_y, input ready);
  modport sink   (input valid, count, sum_x, sum_y, sum_xy, sum_xx, sum_yy, mean_x,
                  mean_y, variance_x, variance_y, deviation_x, deviation_y, output ready);
endinterface

// ===== rtl/rtvs_mul.sv =====
// ----------------------------------------------------------------------------
// rtvs_mul
// bit-serial unsigned multiplier, one multiplier bit per cycle
// ----------------------------------------------------------------------------
module rtvs_mul (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          go_i,
  input  logic [rtvs_pkg::MUL_W-1:0]    a_i,
  input  logic [rtvs_pkg::MUL_W-1:0]    b_i,
  output logic [rtvs_pkg::PROD_W-1:0]   prod_o,
  output rtvs_pkg::rtvs_stat_t          stat_o
);
  import rtvs_pkg::*;

  localparam int unsigned CNT_W = $clog2(MUL_W + 1);

  logic [PROD_W-1:0] a_q;
  logic [MUL_W-1:0]  b_q;
  logic [PROD_W-1:0] p_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              busy_q;
  logic              done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q    <= '0;
      b_q    <= '0;
      p_q    <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (go_i) begin
        a_q    <= PROD_W'(a_i);
        b_q    <= b_i;
        p_q    <= '0;
        cnt_q  <= CNT_W'(MUL_W);
        busy_q <= 1'b1;
      end else if (busy_q) begin
        if (b_q[0]) begin
          p_q <= p_q + a_q;
        end
        a_q   <= {a_q[PROD_W-2:0], 1'b0};
        b_q   <= {1'b0, b_q[MUL_W-1:1]};
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign prod_o      = p_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
endmodule

// ===== rtl/rtvs_div.sv =====
// ----------------------------------------------------------------------------
// rtvs_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module rtvs_div #(
  parameter int unsigned DVS_W = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        go_i,
  input  logic [rtvs_pkg::DIV_W-1:0]  dividend_i,
  input  logic [DVS_W-1:0]            divisor_i,
  output logic [rtvs_pkg::DIV_W-1:0]  quot_o,
  output rtvs_pkg::rtvs_stat_t        stat_o
);
  import rtvs_pkg::*;

  localparam int unsigned CNT_W = $clog2(DIV_W + 1);

  logic [DVS_W-1:0] rem_q;
  logic [DIV_W-1:0] quo_q;
  logic [DVS_W-1:0] d_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q;
  logic             done_q;
  logic [DVS_W:0]   trial;
  logic [DVS_W:0]   diff;
  logic             fits;

  assign trial = {rem_q, quo_q[DIV_W-1]};
  assign diff  = trial - {1'b0, d_q};
  assign fits  = trial >= {1'b0, d_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q  <= '0;
      quo_q  <= '0;
      d_q    <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (go_i) begin
        rem_q  <= '0;
        quo_q  <= dividend_i;
        d_q    <= divisor_i;
        cnt_q  <= CNT_W'(DIV_W);
        busy_q <= 1'b1;
      end else if (busy_q) begin
        rem_q <= fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
        quo_q <= {quo_q[DIV_W-2:0], fits};
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign quot_o      = quo_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
endmodule

// ===== rtl/running_two_variable_statistics_core.sv =====
// ----------------------------------------------------------------------------
// running_two_variable_statistics_core
// running sums, means, sample variances and deviations of x,y pairs
// ----------------------------------------------------------------------------
// in_i carries one word per item: action 0 adds the Q8.8 pair x_sample,
// y_sample, action 1 clears every sum and the count. out_o returns one word
// per item with the count, the five sums, both means (Q8.8), both sample
// variances (Q16.16) and both deviations (Q8.8).
// One item is worked at a time; in_i.ready is high only while idle.
// Products go through a bit-serial multiplier, divisions through a restoring
// divider, and the roots are taken in the core. An add with a count of two
// or more works the three products, the two means, then a variance and root
// per channel, and loads the output; the next item can be accepted from then
// on. With a count of one the variance work is skipped, a full count skips
// the products and a clear goes straight to the output load. A full count
// leaves the sums as they are.
// Reset zeroes the count and all sums. The result sits in an output
// register; while the receiver stalls it holds there and the next item
// may be accepted and worked, but it is not finished until that word left.
// ----------------------------------------------------------------------------
module running_two_variable_statistics_core #(
  parameter int unsigned SAMPLE_WIDTH = 16,
  parameter int unsigned COUNT_WIDTH  = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  rtvs_in_if.sink    in_i,
  rtvs_out_if.source out_o
);
  import rtvs_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_MUL_XY, S_MUL_XX, S_MUL_YY, S_MEAN_GO, S_MEAN,
    S_VAR_GO, S_VSQ, S_VPART, S_VNUM, S_SQRT, S_OUT
  } state_e;

  localparam int unsigned SQ_CNT_W = $clog2(SQRT_STEPS + 1);

  state_e                   state_q;
  logic                     ch_q;
  logic [COUNT_WIDTH-1:0]   cnt_q;
  logic [ACC_W-1:0]         acc_x_q;
  logic [ACC_W-1:0]         acc_y_q;
  logic [XY_W-1:0]          acc_xy_q;
  logic [SQ_W-1:0]          acc_xx_q;
  logic [SQ_W-1:0]          acc_yy_q;
  logic [SAMPLE_WIDTH-1:0]  xs_q;
  logic [SAMPLE_WIDTH-1:0]  ys_q;
  logic [MEAN_W-1:0]        mean_x_q;
  logic [MEAN_W-1:0]        mean_y_q;
  logic [VAR_W-1:0]         var_x_q;
  logic [VAR_W-1:0]         var_y_q;
  logic [DEV_W-1:0]         dev_x_q;
  logic [DEV_W-1:0]         dev_y_q;
  logic [VAR_W-1:0]         sq_v_q;
  logic [VAR_W-1:0]         root_q;
  logic [VAR_W-1:0]         bit_q;
  logic [SQ_CNT_W-1:0]      sq_cnt_q;
  logic                     mul_go_q;
  logic [MUL_W-1:0]         mul_a_q;
  logic [MUL_W-1:0]         mul_b_q;
  logic                     div_go_q;
  logic [DIV_W-1:0]         div_n_q;
  logic [COUNT_WIDTH-1:0]   div_d_q;
  logic                     out_valid_q;
  logic                     mul_go_d;
  logic                     div_go_d;
  logic                     out_valid_d;

  logic [PROD_W-1:0]        mul_p;
  rtvs_stat_t               mul_st;
  logic [DIV_W-1:0]         div_q;
  rtvs_stat_t               div_st;

  logic [ACC_W-1:0]         in_x_ext;
  logic [ACC_W-1:0]         in_y_ext;
  logic [ACC_W-1:0]         x_ext;
  logic [ACC_W-1:0]         y_ext;
  logic [ACC_W-1:0]         x_mag;
  logic [ACC_W-1:0]         y_mag;
  logic [ACC_W-1:0]         acc_sel;
  logic [ACC_W-1:0]         acc_mag;
  logic [SQ_W-1:0]          sq_sel;
  logic [PROD_W-1:0]        prod_xy;
  logic [MEAN_W-1:0]        mean_val;
  logic [VAR_W-1:0]         var_val;
  logic [VAR_W-1:0]         sq_try;
  logic                     cnt_full;
  logic                     cnt_small;
  logic                     out_free;
  logic                     part_big;

  rtvs_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (mul_go_q),
    .a_i    (mul_a_q),
    .b_i    (mul_b_q),
    .prod_o (mul_p),
    .stat_o (mul_st)
  );

  rtvs_div #(.DVS_W(COUNT_WIDTH)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .go_i       (div_go_q),
    .dividend_i (div_n_q),
    .divisor_i  (div_d_q),
    .quot_o     (div_q),
    .stat_o     (div_st)
  );

  assign in_x_ext  = {{(ACC_W-SAMPLE_WIDTH){in_i.x_sample[SAMPLE_WIDTH-1]}}, in_i.x_sample};
  assign in_y_ext  = {{(ACC_W-SAMPLE_WIDTH){in_i.y_sample[SAMPLE_WIDTH-1]}}, in_i.y_sample};
  assign x_ext     = {{(ACC_W-SAMPLE_WIDTH){xs_q[SAMPLE_WIDTH-1]}}, xs_q};
  assign y_ext     = {{(ACC_W-SAMPLE_WIDTH){ys_q[SAMPLE_WIDTH-1]}}, ys_q};
  assign x_mag     = x_ext[ACC_W-1] ? (~x_ext + ACC_W'(1)) : x_ext;
  assign y_mag     = y_ext[ACC_W-1] ? (~y_ext + ACC_W'(1)) : y_ext;
  assign acc_sel   = ch_q ? acc_y_q : acc_x_q;
  assign acc_mag   = acc_sel[ACC_W-1] ? (~acc_sel + ACC_W'(1)) : acc_sel;
  assign sq_sel    = ch_q ? acc_yy_q : acc_xx_q;
  assign prod_xy   = (xs_q[SAMPLE_WIDTH-1] ^ ys_q[SAMPLE_WIDTH-1]) ?
                     (~mul_p + PROD_W'(1)) : mul_p;
  assign mean_val  = acc_sel[ACC_W-1] ? (~div_q[MEAN_W-1:0] + MEAN_W'(1)) : div_q[MEAN_W-1:0];
  assign var_val   = (div_q[DIV_W-1:VAR_W] != '0) ? '1 : div_q[VAR_W-1:0];
  assign sq_try    = root_q + bit_q;
  assign cnt_full  = &cnt_q;
  assign cnt_small = cnt_q < COUNT_WIDTH'(2);
  assign out_free  = !out_valid_q || out_o.ready;
  assign part_big  = div_q > DIV_W'(sq_sel);

  // start pulses for the shared units
  assign mul_go_d = ((state_q == S_IDLE) && in_i.valid && !in_i.action && !cnt_full)
                 || ((state_q == S_MUL_XY) && mul_st.done)
                 || ((state_q == S_MUL_XX) && mul_st.done)
                 || ((state_q == S_VAR_GO) && !cnt_small);
  assign div_go_d = ((state_q == S_MEAN_GO) && (cnt_q != '0))
                 || ((state_q == S_VSQ) && mul_st.done)
                 || ((state_q == S_VPART) && div_st.done && !part_big);
  assign out_valid_d = ((state_q == S_OUT) && out_free) ? 1'b1 :
                       (out_valid_q && out_o.ready) ? 1'b0 : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ch_q        <= 1'b0;
      cnt_q       <= '0;
      acc_x_q     <= '0;
      acc_y_q     <= '0;
      acc_xy_q    <= '0;
      acc_xx_q    <= '0;
      acc_yy_q    <= '0;
      xs_q        <= '0;
      ys_q        <= '0;
      mean_x_q    <= '0;
      mean_y_q    <= '0;
      var_x_q     <= '0;
      var_y_q     <= '0;
      dev_x_q     <= '0;
      dev_y_q     <= '0;
      sq_v_q      <= '0;
      root_q      <= '0;
      bit_q       <= '0;
      sq_cnt_q    <= '0;
      mul_go_q    <= 1'b0;
      mul_a_q     <= '0;
      mul_b_q     <= '0;
      div_go_q    <= 1'b0;
      div_n_q     <= '0;
      div_d_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      mul_go_q    <= mul_go_d;
      div_go_q    <= div_go_d;
      out_valid_q <= out_valid_d;
      unique case (state_q)
        S_IDLE: begin
          ch_q <= 1'b0;
          if (in_i.valid) begin
            if (in_i.action) begin
              cnt_q    <= '0;
              acc_x_q  <= '0;
              acc_y_q  <= '0;
              acc_xy_q <= '0;
              acc_xx_q <= '0;
              acc_yy_q <= '0;
              mean_x_q <= '0;
              mean_y_q <= '0;
              var_x_q  <= '0;
              var_y_q  <= '0;
              dev_x_q  <= '0;
              dev_y_q  <= '0;
              state_q  <= S_OUT;
            end else if (cnt_full) begin
              state_q <= S_MEAN_GO;
            end else begin
              xs_q    <= in_i.x_sample;
              ys_q    <= in_i.y_sample;
              cnt_q   <= cnt_q + COUNT_WIDTH'(1);
              acc_x_q <= acc_x_q + in_x_ext;
              acc_y_q <= acc_y_q + in_y_ext;
              state_q <= S_MUL_XY;
              mul_a_q <= (in_x_ext[ACC_W-1] ? (~in_x_ext + ACC_W'(1)) : in_x_ext);
              mul_b_q <= (in_y_ext[ACC_W-1] ? (~in_y_ext + ACC_W'(1)) : in_y_ext);
            end
          end
        end
        S_MUL_XY: begin
          if (mul_st.done) begin
            acc_xy_q <= acc_xy_q + prod_xy[XY_W-1:0];
            mul_a_q  <= x_mag;
            mul_b_q  <= x_mag;
            state_q  <= S_MUL_XX;
          end
        end
        S_MUL_XX: begin
          if (mul_st.done) begin
            acc_xx_q <= acc_xx_q + mul_p[SQ_W-1:0];
            mul_a_q  <= y_mag;
            mul_b_q  <= y_mag;
            state_q  <= S_MUL_YY;
          end
        end
        S_MUL_YY: begin
          if (mul_st.done) begin
            acc_yy_q <= acc_yy_q + mul_p[SQ_W-1:0];
            state_q  <= S_MEAN_GO;
          end
        end
        S_MEAN_GO: begin
          if (cnt_q == '0) begin
            if (ch_q) begin
              mean_y_q <= '0;
              ch_q     <= 1'b0;
              state_q  <= S_VAR_GO;
            end else begin
              mean_x_q <= '0;
              ch_q     <= 1'b1;
            end
          end else begin
            div_n_q  <= DIV_W'(acc_mag);
            div_d_q  <= cnt_q;
            state_q  <= S_MEAN;
          end
        end
        S_MEAN: begin
          if (div_st.done) begin
            if (ch_q) begin
              mean_y_q <= mean_val;
              ch_q     <= 1'b0;
              state_q  <= S_VAR_GO;
            end else begin
              mean_x_q <= mean_val;
              ch_q     <= 1'b1;
              state_q  <= S_MEAN_GO;
            end
          end
        end
        S_VAR_GO: begin
          if (cnt_small) begin
            var_x_q <= '0;
            var_y_q <= '0;
            dev_x_q <= '0;
            dev_y_q <= '0;
            state_q <= S_OUT;
          end else begin
            mul_a_q  <= acc_mag;
            mul_b_q  <= acc_mag;
            state_q  <= S_VSQ;
          end
        end
        S_VSQ: begin
          if (mul_st.done) begin
            div_n_q  <= mul_p;
            div_d_q  <= cnt_q;
            state_q  <= S_VPART;
          end
        end
        S_VPART: begin
          if (div_st.done) begin
            if (part_big) begin
              // negative numerator reads as zero
              if (ch_q) begin
                var_y_q <= '0;
                dev_y_q <= '0;
                state_q <= S_OUT;
              end else begin
                var_x_q <= '0;
                dev_x_q <= '0;
                ch_q    <= 1'b1;
                state_q <= S_VAR_GO;
              end
            end else begin
              div_n_q  <= DIV_W'(sq_sel - div_q[SQ_W-1:0]);
              div_d_q  <= cnt_q - COUNT_WIDTH'(1);
              state_q  <= S_VNUM;
            end
          end
        end
        S_VNUM: begin
          if (div_st.done) begin
            if (ch_q) begin
              var_y_q <= var_val;
            end else begin
              var_x_q <= var_val;
            end
            sq_v_q   <= var_val;
            root_q   <= '0;
            bit_q    <= VAR_W'(1) << (VAR_W - 2);
            sq_cnt_q <= SQ_CNT_W'(SQRT_STEPS);
            state_q  <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (sq_cnt_q == '0) begin
            if (ch_q) begin
              dev_y_q <= root_q[DEV_W-1:0];
              state_q <= S_OUT;
            end else begin
              dev_x_q <= root_q[DEV_W-1:0];
              ch_q    <= 1'b1;
              state_q <= S_VAR_GO;
            end
          end else begin
            if (sq_v_q >= sq_try) begin
              sq_v_q <= sq_v_q - sq_try;
              root_q <= (root_q >> 1) + bit_q;
            end else begin
              root_q <= root_q >> 1;
            end
            bit_q    <= bit_q >> 2;
            sq_cnt_q <= sq_cnt_q - SQ_CNT_W'(1);
          end
        end
        S_OUT: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // word held in the output stage once loaded; it stays stable while it waits
  logic [CNT_OUT_W-1:0] cnt_out_q;
  logic [ACC_W-1:0]     sx_q, sy_q;
  logic [XY_W-1:0]      sxy_q;
  logic [SQ_W-1:0]      sxx_q, syy_q;
  logic [MEAN_W-1:0]    mx_q, my_q;
  logic [VAR_W-1:0]     vx_q, vy_q;
  logic [DEV_W-1:0]     dx_q, dy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_out_q <= '0;
      sx_q      <= '0;
      sy_q      <= '0;
      sxy_q     <= '0;
      sxx_q     <= '0;
      syy_q     <= '0;
      mx_q      <= '0;
      my_q      <= '0;
      vx_q      <= '0;
      vy_q      <= '0;
      dx_q      <= '0;
      dy_q      <= '0;
    end else if (state_q == S_OUT && out_free) begin
      cnt_out_q <= CNT_OUT_W'(cnt_q);
      sx_q      <= acc_x_q;
      sy_q      <= acc_y_q;
      sxy_q     <= acc_xy_q;
      sxx_q     <= acc_xx_q;
      syy_q     <= acc_yy_q;
      mx_q      <= mean_x_q;
      my_q      <= mean_y_q;
      vx_q      <= var_x_q;
      vy_q      <= var_y_q;
      dx_q      <= dev_x_q;
      dy_q      <= dev_y_q;
    end
  end

  assign in_i.ready        = (state_q == S_IDLE);
  assign out_o.valid       = out_valid_q;
  assign out_o.count       = cnt_out_q;
  assign out_o.sum_x       = sx_q;
  assign out_o.sum_y       = sy_q;
  assign out_o.sum_xy      = sxy_q;
  assign out_o.sum_xx      = sxx_q;
  assign out_o.sum_yy      = syy_q;
  assign out_o.mean_x      = mx_q;
  assign out_o.mean_y      = my_q;
  assign out_o.variance_x  = vx_q;
  assign out_o.variance_y  = vy_q;
  assign out_o.deviation_x = dx_q;
  assign out_o.deviation_y = dy_q;

`include "assert_macros.svh"

  `RTVS_ASSERT(a_cnt_held, (state_q != S_IDLE) |=> $stable(cnt_q))
  `RTVS_ASSERT_NEVER(a_units_excl, mul_st.busy && div_st.busy)
  `RTVS_ASSERT(a_word_from_out, $rose(out_valid_q) |-> $past(state_q == S_OUT))

endmodule

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// directed table and random x,y pairs with clears against a running predictor
// ----------------------------------------------------------------------------
// the predictor keeps its own count and sums, works out means, sample
// variances and deviations per word and queues them; every output word is
// compared field by field with the oldest queued result
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import rtvs_pkg::*;

  typedef enum logic {ACT_ADD = 1'b0, ACT_CLEAR = 1'b1} action_e;
  localparam logic [15:0] COUNT_FULL = 16'hFFFF;
  localparam int unsigned STALL_LIMIT = 20000;

  typedef struct {
    logic [15:0]        count;
    logic signed [31:0] sum_x;
    logic signed [31:0] sum_y;
    logic signed [46:0] sum_xy;
    logic [45:0]        sum_xx;
    logic [45:0]        sum_yy;
    logic signed [15:0] mean_x;
    logic signed [15:0] mean_y;
    logic [31:0]        variance_x;
    logic [31:0]        variance_y;
    logic [15:0]        deviation_x;
    logic [15:0]        deviation_y;
  } stats_t;

  typedef struct {
    action_e     act;
    logic [15:0] x;
    logic [15:0] y;
    bit          known;
    stats_t      res;
  } row_t;

  logic clk_i;
  logic rst_ni;

  rtvs_in_if  in_ch ();
  rtvs_out_if out_ch ();

  running_two_variable_statistics_core u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch.sink),
    .out_o  (out_ch.source)
  );

  logic [15:0]        pair_count;
  logic signed [31:0] run_x;
  logic signed [31:0] run_y;
  logic signed [46:0] run_xy;
  logic [45:0]        run_xx;
  logic [45:0]        run_yy;

  stats_t expected_stats[$];
  row_t   rows[$];
  int     errors;
  int     words_in;
  int     words_out;
  int     clears_sent;
  int     idle_cycles;
  bit     stim_done;
  bit     long_hold;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [31:0] sample_variance(logic [15:0] n, logic signed [31:0] s,
                                                  logic [45:0] sq);
    longint unsigned mag, part, q;
    if (n < 2) return '0;
    mag = (s < 0) ? longint'(-longint'(s)) : longint'(s);
    part = (mag * mag) / n;
    if (part > sq) return '0;
    q = (sq - part) / (n - 1);
    if (q > 64'hFFFF_FFFF) q = 64'hFFFF_FFFF;
    return q[31:0];
  endfunction

  function automatic logic [15:0] root_floor(logic [31:0] v);
    logic [31:0] rem, root, b;
    rem = v;
    root = '0;
    b = 32'h4000_0000;
    while (b > rem) b = b >> 2;
    while (b != 0) begin
      if (rem >= root + b) begin
        rem = rem - (root + b);
        root = (root >> 1) + b;
      end else begin
        root = root >> 1;
      end
      b = b >> 2;
    end
    return root[15:0];
  endfunction

  function automatic stats_t predict_stats(action_e act, logic signed [15:0] x,
                                           logic signed [15:0] y);
    stats_t r;
    longint sx, sy;
    if (act == ACT_CLEAR) begin
      pair_count = '0; run_x = '0; run_y = '0; run_xy = '0; run_xx = '0; run_yy = '0;
    end else if (pair_count != COUNT_FULL) begin
      pair_count = pair_count + 16'd1;
      run_x  = run_x + 32'(x);
      run_y  = run_y + 32'(y);
      run_xy = run_xy + 47'(longint'(x) * longint'(y));
      run_xx = run_xx + 46'(longint'(x) * longint'(x));
      run_yy = run_yy + 46'(longint'(y) * longint'(y));
    end
    r.count  = pair_count;
    r.sum_x  = run_x;
    r.sum_y  = run_y;
    r.sum_xy = run_xy;
    r.sum_xx = run_xx;
    r.sum_yy = run_yy;
    sx = run_x;
    sy = run_y;
    r.mean_x = (pair_count == 0) ? '0 : 16'(sx / longint'(pair_count));
    r.mean_y = (pair_count == 0) ? '0 : 16'(sy / longint'(pair_count));
    r.variance_x  = sample_variance(pair_count, run_x, run_xx);
    r.variance_y  = sample_variance(pair_count, run_y, run_yy);
    r.deviation_x = root_floor(r.variance_x);
    r.deviation_y = root_floor(r.variance_y);
    return r;
  endfunction

  task automatic add_row(action_e act, logic [15:0] x, logic [15:0] y);
    row_t r;
    r.act = act; r.x = x; r.y = y; r.known = 1'b0;
    rows.push_back(r);
  endtask

  task automatic add_known_row(action_e act, logic [15:0] x, logic [15:0] y, stats_t res);
    row_t r;
    r.act = act; r.x = x; r.y = y; r.known = 1'b1; r.res = res;
    rows.push_back(r);
  endtask

  task automatic send_word(action_e act, logic [15:0] x, logic [15:0] y);
    int gap;
    gap = $urandom_range(0, 14);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid    <= 1'b1;
    in_ch.action   <= act;
    in_ch.x_sample <= x;
    in_ch.y_sample <= y;
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  initial begin
    stats_t zero_res, one_res;
    row_t r;
    stats_t p;
    action_e act;
    logic [15:0] x, y;
    int run_len;
    in_ch.valid = 1'b0; in_ch.action = 1'b0; in_ch.x_sample = '0; in_ch.y_sample = '0;
    pair_count = '0; run_x = '0; run_y = '0; run_xy = '0; run_xx = '0; run_yy = '0;
    errors = 0; words_in = 0; words_out = 0; clears_sent = 0;
    stim_done = 1'b0; long_hold = 1'b0;
    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    zero_res = '{default: '0};
    one_res = zero_res;
    one_res.count = 16'd1; one_res.sum_x = 32'sh7FFF; one_res.sum_y = -32'sd32768;
    one_res.sum_xy = -47'sd1073709056; one_res.sum_xx = 46'd1073676289;
    one_res.sum_yy = 46'd1073741824; one_res.mean_x = 16'sh7FFF; one_res.mean_y = 16'sh8000;
    // empty, single sample, extremes, clear
    add_known_row(ACT_CLEAR, 16'h1234, 16'h5678, zero_res);
    add_known_row(ACT_ADD, 16'h7FFF, 16'h8000, one_res);
    add_row(ACT_ADD, 16'h8000, 16'h7FFF);
    add_row(ACT_ADD, 16'h0000, 16'h0000);
    add_row(ACT_ADD, 16'hFFFF, 16'h0001);
    add_row(ACT_ADD, 16'h8000, 16'h8000);
    add_row(ACT_ADD, 16'h7FFF, 16'h7FFF);
    add_row(ACT_ADD, 16'h5555, 16'hAAAA);
    add_known_row(ACT_CLEAR, 16'hFFFF, 16'hFFFF, zero_res);
    add_row(ACT_ADD, 16'h0100, 16'h0100);
    add_row(ACT_ADD, 16'h0100, 16'h0100);
    add_row(ACT_ADD, 16'h0100, 16'hFF00);
    add_row(ACT_ADD, 16'hAAAA, 16'h5555);
    add_row(ACT_ADD, 16'h8000, 16'h8000);
    add_row(ACT_ADD, 16'h8000, 16'h8000);
    add_known_row(ACT_CLEAR, 16'h0000, 16'h0000, zero_res);

    foreach (rows[i]) begin
      r = rows[i];
      p = predict_stats(r.act, r.x, r.y);
      expected_stats.push_back(r.known ? r.res : p);
      if (r.act == ACT_CLEAR) clears_sent++;
      send_word(r.act, r.x, r.y);
      words_in++;
    end

    for (int n = 0; n < 800; n++) begin
      // mostly adds, occasional clear
      run_len = $urandom_range(0, 60);
      act = ($urandom_range(0, 59) == 0) ? ACT_CLEAR : ACT_ADD;
      case ($urandom_range(0, 5))
        0: begin x = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000; y = 16'($urandom); end
        1: begin
          x = 16'($urandom_range(0, 511)) - 16'd256;
          y = 16'($urandom_range(0, 511)) - 16'd256;
        end
        2: begin x = 16'($urandom); y = '0; end
        default: begin x = 16'($urandom); y = 16'($urandom); end
      endcase
      if (run_len == 0) x = 16'h8000;
      if (act == ACT_CLEAR) clears_sent++;
      expected_stats.push_back(predict_stats(act, x, y));
      send_word(act, x, y);
      words_in++;
    end
    in_ch.valid <= 1'b0;
    stim_done = 1'b1;
  end

  // receiver: random stalls, one long hold-off while the sender keeps going
  initial begin
    int gap;
    out_ch.ready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if (!long_hold && words_in >= 40) begin
        long_hold = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (3000) @(posedge clk_i);
      end
      gap = $urandom_range(0, 14);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap != 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!out_ch.valid);
    end
  end

  // compare each accepted output word with the oldest prediction
  always @(posedge clk_i) begin
    stats_t e;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      words_out++;
      if (expected_stats.size() == 0) begin
        $display("%0t: unexpected word, count %0d", $time, out_ch.count);
        errors++;
      end else begin
        e = expected_stats.pop_front();
        if (out_ch.count !== e.count || out_ch.sum_x !== e.sum_x
            || out_ch.sum_y !== e.sum_y || out_ch.sum_xy !== e.sum_xy
            || out_ch.sum_xx !== e.sum_xx || out_ch.sum_yy !== e.sum_yy
            || out_ch.mean_x !== e.mean_x || out_ch.mean_y !== e.mean_y
            || out_ch.variance_x !== e.variance_x || out_ch.variance_y !== e.variance_y
            || out_ch.deviation_x !== e.deviation_x
            || out_ch.deviation_y !== e.deviation_y) begin
          errors++;
          $display("%0t: mismatch exp cnt %0d sx %0d sy %0d sxy %0d sxx %0d syy %0d",
                   $time, e.count, e.sum_x, e.sum_y, e.sum_xy, e.sum_xx, e.sum_yy);
          $display("%0t:   exp mx %0d my %0d vx %0d vy %0d dx %0d dy %0d", $time,
                   e.mean_x, e.mean_y, e.variance_x, e.variance_y, e.deviation_x,
                   e.deviation_y);
          $display("%0t:   got cnt %0d sx %0d sy %0d sxy %0d sxx %0d syy %0d", $time,
                   out_ch.count, out_ch.sum_x, out_ch.sum_y, out_ch.sum_xy,
                   out_ch.sum_xx, out_ch.sum_yy);
          $display("%0t:   got mx %0d my %0d vx %0d vy %0d dx %0d dy %0d", $time,
                   out_ch.mean_x, out_ch.mean_y, out_ch.variance_x, out_ch.variance_y,
                   out_ch.deviation_x, out_ch.deviation_y);
        end
      end
    end
  end

  // watchdog and end of run
  initial begin
    idle_cycles = 0;
    wait (rst_ni === 1'b1);
    while (!(stim_done && expected_stats.size() == 0) && idle_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: timeout, %0d words still expected", $time, expected_stats.size());
      $display("DONE: errors detected");
      $finish;
    end else begin
      repeat (1000) @(posedge clk_i);
      $display("run covered %0d input words (%0d clears) and %0d output words",
               words_in, clears_sent, words_out);
      if (errors == 0 && expected_stats.size() == 0) begin
        $display("DONE: 0 errors");
      end else begin
        $display("DONE: errors detected");
      end
      $finish;
    end
  end

endmodule
